/* src/cpc_pkg.sv */
// shared types, constants and helpers for the clock/power controller register file
// no dependencies
`default_nettype none
package cpc_pkg;

	localparam int WindowBytesDefault = 4096;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_RESET = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		VAR_OLD  = 2'd0,
		VAR_4750 = 2'd1,
		VAR_4755 = 2'd2
	} variant_t;

	localparam logic [11:0] ADDR_CPCCR  = 12'h000;
	localparam logic [11:0] ADDR_LCR    = 12'h004;
	localparam logic [11:0] ADDR_RSR    = 12'h008;
	localparam logic [11:0] ADDR_CPPCR  = 12'h010;
	localparam logic [11:0] ADDR_CPPSR  = 12'h014;
	localparam logic [11:0] ADDR_CLKGR  = 12'h020;
	localparam logic [11:0] ADDR_OPCR   = 12'h024;
	localparam logic [11:0] ADDR_I2SCDR = 12'h060;
	localparam logic [11:0] ADDR_LPCDR  = 12'h064;
	localparam logic [11:0] ADDR_MSCCDR = 12'h068;
	localparam logic [11:0] ADDR_UHCCDR = 12'h06c;
	localparam logic [11:0] ADDR_SSICDR = 12'h074;
	localparam logic [11:0] ADDR_MSC1   = 12'h078;
	localparam logic [11:0] ADDR_PCMCDR = 12'h07c;

	localparam logic [31:0] CPCCR_RST    = 32'h4204_0000;
	localparam logic [31:0] CPPCR_RST    = 32'h2808_0011;
	localparam logic [31:0] CPPCR_MASK   = 32'hffff_03ff;
	localparam logic [31:0] CPCCR_MASK_B = 32'hffef_ffff;
	localparam logic [31:0] CLKGR_MASK_B = 32'h01ff_ffff;
	localparam logic [31:0] CLKGR_MASK_A = 32'h1fff_ffff;
	localparam logic [15:0] OPCR_MASK_B  = 16'hff74;
	localparam logic [15:0] OPCR_MASK_A  = 16'hffd7;
	localparam logic [15:0] SCR_MASK     = 16'hffd0;
	localparam logic [31:0] LPCDR_MASK_A = 32'he000_07ff;
	localparam logic [31:0] LPCDR_MASK_B = 32'hc000_07ff;
	localparam logic [31:0] LPCDR_MASK_O = 32'h8000_07ff;

	localparam logic [1:0]  MODEL_RST = 2'd2;
	localparam logic [39:0] EXT_RST   = 40'd178956970666;
	// periods of the power-on register values: pll bypassed, dividers 1, lcd x8
	localparam logic [63:0] PERIOD_RST = 64'd178956970666;
	localparam logic [63:0] LCD_RST    = 64'd1431655765328;

	// registers the period unit needs
	typedef struct packed {
		logic [31:0] core_ctrl;
		logic [31:0] pll_ctrl;
		logic [31:0] lcd_div;
	} clk_cfg_t;

	// per-item response of the register file
	typedef struct packed {
		logic [31:0] read_data;
		logic        err;
		logic        recompute;
	} resp_t;

	function automatic logic [3:0] div_factor(input logic [3:0] code);
		logic [3:0] f;
		case (code)
			4'd0: f = 4'd1;
			4'd1: f = 4'd2;
			4'd2: f = 4'd3;
			4'd3: f = 4'd4;
			4'd4: f = 4'd6;
			4'd5: f = 4'd8;
			default: f = 4'd1;
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

/* src/cpc_regfile.sv */
// register file: decode, write masks, read aliases and reset defaults
// depends on cpc_pkg
`default_nettype none
module cpc_regfile #(
	parameter int WINDOW_BYTES = cpc_pkg::WindowBytesDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [1:0]        req_type,
	input  wire logic [11:0]       address,
	input  wire logic [31:0]       write_data,
	input  wire logic [3:0]        access_size,
	input  wire logic [1:0]        variant,
	output cpc_pkg::resp_t         resp,
	output cpc_pkg::clk_cfg_t      clk_cfg
);
	import cpc_pkg::*;

	logic [31:0] core_q, pll_q, clkgr_q, lpcdr_q;
	logic        cppsr_q;
	logic [7:0]  lcr_q;
	logic [1:0]  rsr_q;
	logic [15:0] opcr_q, scr_q;
	logic [8:0]  i2s_q;
	logic [4:0]  msc_q, msc0_q, msc1_q;
	logic [3:0]  uhc_q;
	logic [2:0]  ssi_q, pcm_q, cim_q;

	logic        ok;
	logic        hit;
	logic        wr_ok;
	logic [31:0] rval;
	logic [31:0] pll_w;
	logic        is_old, is_a, is_b;

	assign is_old = (variant == VAR_OLD);
	assign is_a   = (variant == VAR_4750);
	assign is_b   = !is_old && !is_a;
	assign ok = (access_size == 4'd4) && (address[1:0] == 2'b00)
		&& ({5'd0, address} < 17'(WINDOW_BYTES));
	assign pll_w = (write_data & CPPCR_MASK) | {21'd0, write_data[8], 10'd0};

	always_comb begin
		hit  = 1'b1;
		rval = '0;
		case (address)
			ADDR_CPCCR:  rval = core_q;
			ADDR_LCR:    rval = {24'd0, lcr_q};
			ADDR_RSR:    rval = {30'd0, rsr_q};
			ADDR_CPPCR:  rval = pll_q;
			ADDR_CPPSR:  rval = {cppsr_q, 31'd0};
			ADDR_CLKGR:  rval = clkgr_q;
			ADDR_OPCR:   rval = {16'd0, is_old ? scr_q : opcr_q};
			ADDR_I2SCDR: rval = {23'd0, i2s_q};
			ADDR_LPCDR:  rval = lpcdr_q;
			ADDR_MSCCDR: rval = {27'd0, is_a ? msc0_q : msc_q};
			ADDR_UHCCDR: rval = {28'd0, uhc_q};
			ADDR_SSICDR: rval = {29'd0, ssi_q};
			ADDR_MSC1:   rval = {27'd0, msc1_q};
			ADDR_PCMCDR: rval = {29'd0, is_b ? cim_q : pcm_q};
			default:     hit = 1'b0;
		endcase
	end

	always_comb begin
		case (address)
			ADDR_CPCCR, ADDR_LCR, ADDR_RSR, ADDR_CPPCR, ADDR_CLKGR, ADDR_OPCR,
			ADDR_I2SCDR, ADDR_LPCDR, ADDR_MSCCDR, ADDR_MSC1, ADDR_UHCCDR:
				wr_ok = 1'b1;
			default: wr_ok = 1'b0;
		endcase
	end

	always_comb begin
		resp = '0;
		case (req_type)
			REQ_READ: begin
				resp.err       = !(ok && hit);
				resp.read_data = (ok && hit) ? rval : 32'd0;
			end
			REQ_WRITE: begin
				resp.err       = !(ok && wr_ok);
				resp.recompute = ok && ((address == ADDR_CPCCR) ||
					(address == ADDR_CPPCR) || (address == ADDR_LPCDR));
			end
			REQ_RESET: resp.recompute = 1'b1;
			default: resp = '0;
		endcase
	end

	assign clk_cfg.core_ctrl = core_q;
	assign clk_cfg.pll_ctrl  = pll_q;
	assign clk_cfg.lcd_div   = lpcdr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_q <= CPCCR_RST; pll_q <= CPPCR_RST; cppsr_q <= 1'b1;
			lcr_q <= 8'hf8; rsr_q <= 2'd1; clkgr_q <= '0; opcr_q <= 16'h1500;
			scr_q <= 16'h1500; i2s_q <= 9'd4; lpcdr_q <= 32'd4; msc_q <= '0;
			msc0_q <= '0; msc1_q <= '0; uhc_q <= 4'd4; ssi_q <= '0;
			pcm_q <= 3'd4; cim_q <= 3'd4;
		end else if (accept && req_type == REQ_RESET) begin
			core_q <= CPCCR_RST; pll_q <= CPPCR_RST; cppsr_q <= !is_old;
			lcr_q <= 8'hf8; rsr_q <= 2'd1; clkgr_q <= '0; opcr_q <= 16'h1500;
			scr_q <= 16'h1500; i2s_q <= 9'd4; lpcdr_q <= 32'd4;
			msc_q <= is_old ? 5'd4 : 5'd0; msc0_q <= '0; msc1_q <= '0;
			uhc_q <= 4'd4; ssi_q <= is_old ? 3'd4 : 3'd0;
			pcm_q <= 3'd4; cim_q <= 3'd4;
		end else if (accept && req_type == REQ_WRITE && ok) begin
			case (address)
				ADDR_CPCCR:  core_q <= is_b ? (write_data & CPCCR_MASK_B) : write_data;
				ADDR_LCR:    lcr_q <= write_data[7:0];
				ADDR_RSR:    rsr_q <= rsr_q & write_data[1:0];
				ADDR_CPPCR:  pll_q <= pll_w;
				ADDR_CLKGR:  clkgr_q <= is_b ? (write_data & CLKGR_MASK_B)
					: is_a ? (write_data & CLKGR_MASK_A) : {16'd0, write_data[15:0]};
				ADDR_OPCR: begin
					if (is_b) opcr_q <= write_data[15:0] & OPCR_MASK_B;
					else if (is_a) opcr_q <= write_data[15:0] & OPCR_MASK_A;
					else scr_q <= write_data[15:0] & SCR_MASK;
				end
				ADDR_I2SCDR: i2s_q <= write_data[8:0];
				ADDR_LPCDR:  lpcdr_q <= is_b ? (write_data & LPCDR_MASK_B)
					: is_a ? (write_data & LPCDR_MASK_A) : (write_data & LPCDR_MASK_O);
				ADDR_MSCCDR: begin
					if (is_a) msc0_q <= write_data[4:0];
					else msc_q <= write_data[4:0];
				end
				ADDR_MSC1:   msc1_q <= write_data[4:0];
				ADDR_UHCCDR: uhc_q <= write_data[3:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/cpc_period_unit.sv */
// bit-serial period calculator: shift-add multiply, restoring divide, scaling lanes
// depends on cpc_pkg
`default_nettype none
module cpc_period_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [39:0]       ext_period,
	input  cpc_pkg::clk_cfg_t      clk_cfg,
	output logic                   busy,
	output logic                   done,
	output logic [63:0]            pll_period,
	output logic [63:0]            cpu_clock_period,
	output logic [63:0]            memory_clock_period,
	output logic [63:0]            peripheral_clock_period,
	output logic [63:0]            lcd_pixel_period
);
	import cpc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_SCALE} state_t;

	state_t      state_q;
	logic [5:0]  cnt_q;
	logic [47:0] acc_q, mcand_q;
	logic [7:0]  mplier_q;
	logic [9:0]  m_q, rem_q;
	logic [63:0] base_q, a_cpu_q, a_mem_q, a_per_q, a_lcd_q;
	logic [3:0]  f_cpu_q, f_mem_q, f_per_q;
	logic [11:0] f_lcd_q;
	logic [31:0] core_q;
	logic [10:0] lcd_q;

	logic        pll_on;
	logic [5:0]  n_val;
	logic [7:0]  factor;
	logic [1:0]  od_sh;
	logic [10:0] trial;
	logic        q_bit;

	assign pll_on = (clk_cfg.pll_ctrl[9:8] == 2'b01);
	assign n_val  = 6'(clk_cfg.pll_ctrl[22:18]) + 6'd2;
	always_comb begin
		case (clk_cfg.pll_ctrl[17:16])
			2'd0: od_sh = 2'd0;
			2'd3: od_sh = 2'd2;
			default: od_sh = 2'd1;
		endcase
	end
	assign factor = pll_on ? (8'(n_val) << od_sh) : 8'd1;
	assign trial  = {rem_q, acc_q[47]};
	assign q_bit  = (trial >= {1'b0, m_q});
	assign busy   = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
			pll_period <= PERIOD_RST;
			cpu_clock_period <= PERIOD_RST;
			memory_clock_period <= PERIOD_RST;
			peripheral_clock_period <= PERIOD_RST;
			lcd_pixel_period <= LCD_RST;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						acc_q    <= '0;
						mcand_q  <= {8'd0, ext_period};
						mplier_q <= factor;
						m_q      <= pll_on ? (10'(clk_cfg.pll_ctrl[31:23]) + 10'd2) : 10'd1;
						core_q   <= clk_cfg.core_ctrl;
						lcd_q    <= clk_cfg.lcd_div[10:0];
						cnt_q    <= 6'd7;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mplier_q[0]) acc_q <= acc_q + mcand_q;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						rem_q   <= '0;
						cnt_q   <= 6'd47;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// quotient shifts in where the dividend shifts out
					rem_q <= q_bit ? 10'(trial - {1'b0, m_q}) : trial[9:0];
					acc_q <= {acc_q[46:0], q_bit};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						base_q  <= {16'd0, acc_q[46:0], q_bit};
						a_cpu_q <= '0; a_mem_q <= '0; a_per_q <= '0; a_lcd_q <= '0;
						f_cpu_q <= div_factor(core_q[3:0]);
						f_mem_q <= div_factor(core_q[15:12]);
						f_per_q <= div_factor(core_q[11:8]);
						f_lcd_q <= core_q[21] ? {1'b0, lcd_q} : {lcd_q, 1'b0};
						cnt_q   <= 6'd11;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (f_cpu_q[0]) a_cpu_q <= a_cpu_q + base_q;
					if (f_mem_q[0]) a_mem_q <= a_mem_q + base_q;
					if (f_per_q[0]) a_per_q <= a_per_q + base_q;
					if (f_lcd_q[0]) a_lcd_q <= a_lcd_q + base_q;
					base_q  <= base_q << 1;
					f_cpu_q <= f_cpu_q >> 1;
					f_mem_q <= f_mem_q >> 1;
					f_per_q <= f_per_q >> 1;
					f_lcd_q <= f_lcd_q >> 1;
					cnt_q   <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						pll_period <= base_q >> 11;
						cpu_clock_period        <= a_cpu_q;
						memory_clock_period     <= a_mem_q;
						peripheral_clock_period <= a_per_q;
						lcd_pixel_period <= f_lcd_q[0] ? a_lcd_q + base_q : a_lcd_q;
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/clock_power_controller_regs.sv */
// top level of the clock/power controller register file
// depends on cpc_pkg, cpc_regfile, cpc_period_unit
`default_nettype none
// one item per start pulse while busy is low; the result appears for one cycle
// with done high and the receiver cannot stall it. reads, and writes that leave
// the clock periods alone, answer in the cycle after start and busy never rises.
// an aligned word write to CPCCR, CPPCR or LPCDR, or a reset request, runs the
// bit-serial period unit: 8 multiply steps, 48 divide steps and 12 scaling steps,
// one after another; busy stays high until done. the five period outputs hold
// their last value, change only as a recompute ends and are valid when its done
// rises. crystal writes take effect at the next recompute, model writes at once.
module clock_power_controller_regs #(
	parameter int WINDOW_BYTES = cpc_pkg::WindowBytesDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [39:0] cfg_data,
	// item in
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [11:0] address,
	input  wire logic [31:0] write_data,
	input  wire logic [3:0]  access_size,
	// result out
	output logic             done,
	output logic [31:0]      read_data,
	output logic             access_error,
	output logic [63:0]      pll_period,
	output logic [63:0]      cpu_clock_period,
	output logic [63:0]      memory_clock_period,
	output logic [63:0]      peripheral_clock_period,
	output logic [63:0]      lcd_pixel_period
);
	import cpc_pkg::*;

	typedef enum logic [1:0] {T_IDLE, T_LAUNCH, T_CALC} top_state_t;

	top_state_t  state_q;
	logic [1:0]  model_q;
	logic [39:0] ext_q;
	logic        accept;
	logic [1:0]  variant;
	resp_t       resp;
	clk_cfg_t    clk_cfg;
	logic        calc_busy, calc_done;

	assign accept  = start && !busy;
	assign busy    = (state_q != T_IDLE);
	// code 3 behaves as the newest variant
	assign variant = (model_q == 2'd3) ? VAR_4755 : model_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= MODEL_RST;
			ext_q   <= EXT_RST;
		end else if (cfg_we) begin
			if (cfg_index) ext_q <= cfg_data;
			else model_q <= cfg_data[1:0];
		end
	end

	cpc_regfile #(.WINDOW_BYTES(WINDOW_BYTES)) u_regs (
		.clk, .arst_n, .accept, .req_type, .address, .write_data, .access_size,
		.variant, .resp, .clk_cfg
	);

	// launch in the cycle after accept so the unit sees the updated registers
	cpc_period_unit u_period (
		.clk, .arst_n,
		.start(state_q == T_LAUNCH),
		.ext_period(ext_q),
		.clk_cfg,
		.busy(calc_busy),
		.done(calc_done),
		.pll_period, .cpu_clock_period, .memory_clock_period,
		.peripheral_clock_period, .lcd_pixel_period
	);

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			done <= 1'b0;
			read_data <= '0;
			access_error <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						read_data    <= resp.read_data;
						access_error <= resp.err;
						if (resp.recompute) state_q <= T_LAUNCH;
						else done <= 1'b1;
					end
				end
				T_LAUNCH: state_q <= T_CALC;
				T_CALC: begin
					if (calc_done) begin
						done    <= 1'b1;
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// the period unit only runs inside a recompute item
	a_calc_in_item: assert property (@(posedge clk) disable iff (!arst_n)
		calc_busy |-> busy) else $error("period unit running outside an item");
	// the end of a recompute is reported as a result next cycle
	a_calc_done: assert property (@(posedge clk) disable iff (!arst_n)
		calc_done |=> done) else $error("recompute finished without a result");
	// an error result never carries read data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && access_error) |-> (read_data == 32'd0))
		else $error("read data on an error result");

endmodule
`default_nettype wire

/* verif/cpc_checker.sv */
// checker for the clock/power controller register file: predicts every result
// from the accepted items and the configuration writes and compares field by field
// depends on cpc_pkg
`default_nettype none
module cpc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [39:0] cfg_data,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [11:0] address,
	input  wire logic [31:0] write_data,
	input  wire logic [3:0]  access_size,
	input  wire logic        done,
	input  wire logic [31:0] read_data,
	input  wire logic        access_error,
	input  wire logic [63:0] pll_period,
	input  wire logic [63:0] cpu_clock_period,
	input  wire logic [63:0] memory_clock_period,
	input  wire logic [63:0] peripheral_clock_period,
	input  wire logic [63:0] lcd_pixel_period,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import cpc_pkg::*;

	typedef struct {
		logic [31:0] rdata;
		logic        err;
		logic [63:0] per [5];
	} bus_result_t;

	bus_result_t expected_q [$];
	logic [1:0]  model;
	logic [39:0] ext;
	logic [31:0] cpccr, cppcr, cppsr, lcr, rsr, clkgr, opcr, scr, i2s, lpcdr;
	logic [31:0] msccdr, msc0cdr, msc1cdr, uhccdr, ssicdr, pcmcdr, cimcdr;
	logic [63:0] periods [5];

	function automatic logic [63:0] div_mult(input logic [3:0] code);
		case (code)
			4'd0: return 1;
			4'd1: return 2;
			4'd2: return 3;
			4'd3: return 4;
			4'd4: return 6;
			4'd5: return 8;
			default: return 1;
		endcase
	endfunction

	task automatic update_periods();
		logic [63:0] pll, m, n, od, pcs;
		if (cppcr[9:8] == 2'b01) begin
			m = cppcr[31:23] + 2;
			n = cppcr[22:18] + 2;
			case (cppcr[17:16])
				2'd0: od = 1;
				2'd3: od = 4;
				default: od = 2;
			endcase
			pll = ({24'd0, ext} * (n * od)) / m;
		end else begin
			pll = {24'd0, ext};
		end
		periods[0] = pll;
		periods[1] = pll * div_mult(cpccr[3:0]);
		periods[2] = pll * div_mult(cpccr[15:12]);
		periods[3] = pll * div_mult(cpccr[11:8]);
		pcs = cpccr[21] ? pll : pll * 2;
		periods[4] = pcs * {53'd0, lpcdr[10:0]};
	endtask

	function automatic variant_t cur_variant();
		return (model >= 2) ? VAR_4755 : variant_t'(model);
	endfunction

	task automatic load_defaults();
		variant_t v;
		v = cur_variant();
		cpccr = CPCCR_RST;
		cppcr = CPPCR_RST;
		cppsr = (v != VAR_OLD) ? 32'h8000_0000 : 0;
		lcr = 32'hf8;
		rsr = 1;
		clkgr = 0;
		opcr = 32'h1500;
		scr = 32'h1500;
		i2s = 4;
		lpcdr = 4;
		msccdr = (v == VAR_OLD) ? 4 : 0;
		msc0cdr = 0;
		msc1cdr = 0;
		uhccdr = 4;
		ssicdr = (v == VAR_OLD) ? 4 : 0;
		pcmcdr = 4;
		cimcdr = 4;
		update_periods();
	endtask

	task automatic predict_item(input logic [1:0] rt, input logic [11:0] a,
			input logic [31:0] d, input logic [3:0] sz);
		bus_result_t r;
		variant_t v;
		logic hit;
		v = cur_variant();
		r.rdata = 0;
		r.err = 0;
		hit = 1;
		if (rt == REQ_RESET) begin
			load_defaults();
		end else if (rt == REQ_READ || rt == REQ_WRITE) begin
			if (sz != 4 || a[1:0] != 0) begin
				r.err = 1;
			end else if (rt == REQ_READ) begin
				case (a)
					ADDR_CPCCR: r.rdata = cpccr;
					ADDR_LCR: r.rdata = lcr;
					ADDR_RSR: r.rdata = rsr;
					ADDR_CPPCR: r.rdata = cppcr;
					ADDR_CPPSR: r.rdata = cppsr;
					ADDR_CLKGR: r.rdata = clkgr;
					ADDR_OPCR: r.rdata = (v != VAR_OLD) ? opcr : scr;
					ADDR_I2SCDR: r.rdata = i2s;
					ADDR_LPCDR: r.rdata = lpcdr;
					ADDR_MSCCDR: r.rdata = (v == VAR_4750) ? msc0cdr : msccdr;
					ADDR_UHCCDR: r.rdata = uhccdr;
					ADDR_SSICDR: r.rdata = ssicdr;
					ADDR_MSC1: r.rdata = msc1cdr;
					ADDR_PCMCDR: r.rdata = (v == VAR_4755) ? cimcdr : pcmcdr;
					default: hit = 0;
				endcase
				r.err = !hit;
			end else begin
				case (a)
					ADDR_CPCCR: begin
						cpccr = (v == VAR_4755) ? (d & CPCCR_MASK_B) : d;
						update_periods();
					end
					ADDR_LCR: lcr = d & 32'hff;
					ADDR_RSR: rsr = rsr & d & 32'h3;
					ADDR_CPPCR: begin
						cppcr = d & CPPCR_MASK;
						if (cppcr[8])
							cppcr[10] = 1'b1;
						update_periods();
					end
					ADDR_CLKGR: clkgr = (v == VAR_4755) ? (d & CLKGR_MASK_B)
						: (v == VAR_4750) ? (d & CLKGR_MASK_A) : (d & 32'hffff);
					ADDR_OPCR: begin
						if (v == VAR_4755) opcr = d & OPCR_MASK_B;
						else if (v == VAR_4750) opcr = d & OPCR_MASK_A;
						else scr = d & SCR_MASK;
					end
					ADDR_I2SCDR: i2s = d & 32'h1ff;
					ADDR_LPCDR: begin
						lpcdr = (v == VAR_4755) ? (d & LPCDR_MASK_B)
							: (v == VAR_4750) ? (d & LPCDR_MASK_A) : (d & LPCDR_MASK_O);
						update_periods();
					end
					ADDR_MSCCDR: begin
						if (v == VAR_4750) msc0cdr = d & 32'h1f;
						else msccdr = d & 32'h1f;
					end
					ADDR_MSC1: msc1cdr = d & 32'h1f;
					ADDR_UHCCDR: uhccdr = d & 32'hf;
					default: hit = 0;
				endcase
				r.err = !hit;
			end
		end
		for (int i = 0; i < 5; i++)
			r.per[i] = periods[i];
		expected_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		bus_result_t e;
		logic [63:0] got [5];
		if (!arst_n) begin
			model = MODEL_RST;
			ext = EXT_RST;
			load_defaults();
			expected_q.delete();
			fail_count = 0;
		end else begin
			// results first: a done seen at this edge belongs to an older item
			if (done) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					e = expected_q.pop_front();
					got[0] = pll_period;
					got[1] = cpu_clock_period;
					got[2] = memory_clock_period;
					got[3] = peripheral_clock_period;
					got[4] = lcd_pixel_period;
					if (read_data !== e.rdata) report_mismatch("read_data", read_data, e.rdata);
					if (access_error !== e.err)
						report_mismatch("access_error", access_error, e.err);
					for (int i = 0; i < 5; i++)
						if (got[i] !== e.per[i]) report_mismatch($sformatf("period %0d", i),
							got[i], e.per[i]);
				end
			end
			if (cfg_we) begin
				if (cfg_index == 1'b0) model = cfg_data[1:0];
				else ext = cfg_data;
			end
			if (start && !busy)
				predict_item(req_type, address, write_data, access_size);
		end
	end
endmodule
`default_nettype wire

/* verif/clock_power_controller_regs_tb.sv */
// testbench top for clock_power_controller_regs: directed and random bus items
// under several variant and crystal settings, checked by cpc_checker
// depends on cpc_pkg, cpc_checker and the block
`default_nettype none
module clock_power_controller_regs_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cpc_pkg::*;

	localparam int CycleLimit = 400000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [39:0] cfg_data;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [11:0] address;
	logic [31:0] write_data;
	logic [3:0]  access_size;
	logic        done;
	logic [31:0] read_data;
	logic        access_error;
	logic [63:0] pll_period, cpu_clock_period, memory_clock_period;
	logic [63:0] peripheral_clock_period, lcd_pixel_period;
	int          fail_count;
	int          pending;
	int          cycles;

	clock_power_controller_regs u_top (.*);

	cpc_checker u_checker (.*);

	// register addresses the random part picks from
	logic [11:0] reg_addrs [14] = '{ADDR_CPCCR, ADDR_LCR, ADDR_RSR, ADDR_CPPCR, ADDR_CPPSR,
		ADDR_CLKGR, ADDR_OPCR, ADDR_I2SCDR, ADDR_LPCDR, ADDR_MSCCDR, ADDR_UHCCDR,
		ADDR_SSICDR, ADDR_MSC1, ADDR_PCMCDR};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog, counts every cycle of the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// hand one item over and wait until the block takes it;
	// start stays high so a following item can go back to back
	task automatic send_item(input logic [1:0] rt, input logic [11:0] a,
			input logic [31:0] d, input logic [3:0] sz);
		start <= 1'b1;
		req_type <= rt;
		address <= a;
		write_data <= d;
		access_size <= sz;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// random gap in front of an item, often none
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// let the block drain fully, including a write still in the period unit
	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [39:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly legal accesses to real registers, some noise and resets
	task automatic random_item();
		logic [1:0]  rt;
		logic [11:0] a;
		logic [31:0] d;
		logic [3:0]  sz;
		int k;
		k = $urandom_range(0, 99);
		rt = (k < 45) ? REQ_READ : (k < 90) ? REQ_WRITE : (k < 95) ? REQ_RESET : REQ_NONE;
		a = reg_addrs[$urandom_range(0, 13)];
		if ($urandom_range(0, 9) == 0) a = 12'($urandom);
		sz = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd4;
		d = $urandom;
		// bias the pll control toward enabled and not bypassed
		if (a == ADDR_CPPCR && $urandom_range(0, 1)) d[9:8] = 2'b01;
		send_item(rt, a, d, sz);
	endtask

	initial begin
		logic [39:0] ext_set [4];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		start = 1'b0;
		req_type = REQ_READ;
		address = '0;
		write_data = '0;
		access_size = 4'd4;
		cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, extremes, error paths, pll on, rsr clear
		for (int i = 0; i < 14; i += 2) send_item(REQ_READ, reg_addrs[i], 32'd0, 4'd4);
		send_item(REQ_READ, 12'h002, 32'd0, 4'd4);
		send_item(REQ_READ, ADDR_CPCCR, 32'd0, 4'd8);
		send_item(REQ_READ, 12'hffc, 32'd0, 4'd15);
		send_item(REQ_READ, 12'hffc, 32'd0, 4'd4);
		send_item(REQ_WRITE, ADDR_CPPSR, 32'hffff_ffff, 4'd4);
		send_item(REQ_WRITE, ADDR_SSICDR, 32'hffff_ffff, 4'd4);
		send_item(REQ_WRITE, ADDR_PCMCDR, 32'hffff_ffff, 4'd4);
		send_item(REQ_WRITE, ADDR_RSR, 32'h0, 4'd4);
		send_item(REQ_WRITE, ADDR_CPPCR, 32'hffff_fdff, 4'd4);
		send_item(REQ_WRITE, ADDR_CPCCR, 32'hffff_ffff, 4'd4);
		send_item(REQ_WRITE, ADDR_LPCDR, 32'hffff_ffff, 4'd4);
		send_item(REQ_WRITE, ADDR_CPPCR, 32'h0, 4'd4);
		send_item(REQ_NONE, 12'h0, 32'd0, 4'd0);
		send_item(REQ_RESET, 12'h3, 32'hffff_ffff, 4'd0);
		drain();

		// variant sweep including the folded code, with crystal extremes
		ext_set = '{40'd1, 40'hff_ffff_ffff, 40'd178956970666, 40'd0};
		for (int phase = 0; phase < 8; phase++) begin
			write_cfg(1'b0, 40'(phase % 4));
			ext_set[3] = 40'($urandom) | 40'd1;
			write_cfg(1'b1, ext_set[phase % 4]);
			send_item(REQ_RESET, 12'd0, 32'd0, 4'd4);
			for (int i = 0; i < 68; i++) begin
				idle_gap();
				random_item();
			end
			// hold off until everything from this phase has come back
			drain();
		end

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
src/cpc_pkg.sv
src/cpc_regfile.sv
src/cpc_period_unit.sv
src/clock_power_controller_regs.sv
verif/cpc_checker.sv
verif/clock_power_controller_regs_tb.sv
